[sv/tbrc_pkg.sv]
// Shared types and constants for the two-button release and combo detector.
// No dependencies; every other file of the block imports this package.
package tbrc_pkg;

  // Width of the millisecond timestamp carried on the input channel.
  localparam int unsigned NOW_W = 32;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Reset values of the timing registers.
  localparam logic [CFG_DATA_W-1:0] COMBO_THRESHOLD_RESET = 32'd5000;
  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RESET        = 32'd50;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COMBO_THRESHOLD = 3'd0,
    REG_DEBOUNCE        = 3'd1,
    REG_INC_ENABLE      = 3'd2,
    REG_DEC_ENABLE      = 3'd3,
    REG_COMBO_ENABLE    = 3'd4
  } cfg_reg_t;

  // One result beat.
  typedef struct packed {
    logic inc_event;
    logic dec_event;
    logic combo_event;
  } result_t;

endpackage

[sv/tbrc_in_if.sv]
// Input channel of the detector: one beat is one sample of both button pins
// and a timestamp. Depends on tbrc_pkg.
interface tbrc_in_if import tbrc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             inc_level;
  logic             dec_level;
  logic [NOW_W-1:0] now_ms;

  modport source (output valid, output inc_level, output dec_level, output now_ms,
                  input ready);
  modport sink   (input valid, input inc_level, input dec_level, input now_ms,
                  output ready);
endinterface

[sv/tbrc_out_if.sv]
// Result channel of the detector: one beat carries the three event flags.
// Depends on tbrc_pkg only through the importing convention.
interface tbrc_out_if import tbrc_pkg::*; ();
  logic valid;
  logic ready;
  logic inc_event;
  logic dec_event;
  logic combo_event;

  modport source (output valid, output inc_event, output dec_event,
                  output combo_event, input ready);
  modport sink   (input valid, input inc_event, input dec_event,
                  input combo_event, output ready);
endinterface

[sv/tbrc_cfg_if.sv]
// Configuration write channel of the detector: register index and data.
// Depends on tbrc_pkg for the port geometry.
interface tbrc_cfg_if import tbrc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/two_button_release_and_combo_detector.sv]
// Two-button release and combo detector. Each input beat is one sample of
// the active-low increment and decrement pins with a millisecond timestamp,
// and each one yields exactly one result beat with three event flags. A
// release fires its button's event when the press lasted at least the
// debounce time, the button is enabled, and no moment with both buttons held
// has been seen since that button's previous release. While both buttons are
// held a hold timer runs; the combo event fires at most once per hold, on a
// later sample of the hold whose elapsed time reaches the combo threshold. All
// time differences wrap modulo 2^TIME_BITS. The block takes one beat per clock
// while the output is not stalled: a sample is captured in an input register,
// the state update and event decision happen in a single combinational pass,
// and the result lands in an output register; both sides may stall freely.
// Configuration writes are always accepted and should only be issued while
// no sample is in flight. There is no clearing pass after reset.
// Depends on tbrc_pkg and the three channel interfaces.
module two_button_release_and_combo_detector import tbrc_pkg::*; #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  tbrc_in_if.sink    in_bus,
  tbrc_out_if.source out_bus,
  tbrc_cfg_if.sink   cfg_bus
);

  // Comparisons run at the wider of the time width and the register width.
  localparam int unsigned CMP_W = (TIME_BITS > CFG_DATA_W) ? TIME_BITS : CFG_DATA_W;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] combo_thresh_r;
  logic [CFG_DATA_W-1:0] debounce_r;
  logic                  inc_en_r;
  logic                  dec_en_r;
  logic                  combo_en_r;

  // Input register.
  logic                 s1_v_r;
  logic                 s1_inc_r;
  logic                 s1_dec_r;
  logic [TIME_BITS-1:0] s1_now_r;

  // Detector state.
  logic                 inc_prev_r, inc_prev_nxt;
  logic [TIME_BITS-1:0] inc_press_r, inc_press_nxt;
  logic                 inc_skip_r, inc_skip_nxt;
  logic                 dec_prev_r, dec_prev_nxt;
  logic [TIME_BITS-1:0] dec_press_r, dec_press_nxt;
  logic                 dec_skip_r, dec_skip_nxt;
  logic                 hold_active_r, hold_active_nxt;
  logic [TIME_BITS-1:0] hold_start_r, hold_start_nxt;
  logic                 hold_done_r, hold_done_nxt;

  // Output register.
  logic    out_v_r;
  result_t out_res_r;
  result_t res_nxt;

  logic                 advance;
  logic                 both_low;
  logic                 inc_skip_mid;
  logic                 dec_skip_mid;
  logic [TIME_BITS-1:0] inc_elapsed;
  logic [TIME_BITS-1:0] dec_elapsed;
  logic [TIME_BITS-1:0] hold_elapsed;

  // The sample in the input register moves on whenever the output register
  // is empty or is being emptied in this cycle.
  assign advance      = s1_v_r && (!out_v_r || out_bus.ready);
  assign in_bus.ready = !s1_v_r || advance;
  assign cfg_bus.ready = 1'b1;

  assign out_bus.valid       = out_v_r;
  assign out_bus.inc_event   = out_res_r.inc_event;
  assign out_bus.dec_event   = out_res_r.dec_event;
  assign out_bus.combo_event = out_res_r.combo_event;

  assign inc_elapsed  = s1_now_r - inc_press_r;
  assign dec_elapsed  = s1_now_r - dec_press_r;
  assign hold_elapsed = s1_now_r - hold_start_r;

  always_comb begin
    both_low        = !s1_inc_r && !s1_dec_r;
    res_nxt         = '0;
    hold_active_nxt = hold_active_r;
    hold_start_nxt  = hold_start_r;
    hold_done_nxt   = hold_done_r;

    // A sample with both buttons held cancels both pending releases and
    // runs the hold timer.
    inc_skip_mid = both_low ? 1'b1 : inc_skip_r;
    dec_skip_mid = both_low ? 1'b1 : dec_skip_r;
    if (both_low) begin
      if (!hold_active_r) begin
        hold_active_nxt = 1'b1;
        hold_start_nxt  = s1_now_r;
        hold_done_nxt   = 1'b0;
      end else if (!hold_done_r &&
                   (CMP_W'(hold_elapsed) >= CMP_W'(combo_thresh_r))) begin
        hold_done_nxt       = 1'b1;
        res_nxt.combo_event = combo_en_r;
      end
    end else begin
      hold_active_nxt = 1'b0;
    end

    // Increment button: a press records the time, a release decides.
    inc_press_nxt = inc_press_r;
    inc_skip_nxt  = inc_skip_mid;
    if (inc_prev_r && !s1_inc_r) begin
      inc_press_nxt = s1_now_r;
    end else if (!inc_prev_r && s1_inc_r) begin
      res_nxt.inc_event = (CMP_W'(inc_elapsed) >= CMP_W'(debounce_r)) &&
                          inc_en_r && !inc_skip_mid;
      inc_skip_nxt      = 1'b0;
    end
    inc_prev_nxt = s1_inc_r;

    // Decrement button, the same rules.
    dec_press_nxt = dec_press_r;
    dec_skip_nxt  = dec_skip_mid;
    if (dec_prev_r && !s1_dec_r) begin
      dec_press_nxt = s1_now_r;
    end else if (!dec_prev_r && s1_dec_r) begin
      res_nxt.dec_event = (CMP_W'(dec_elapsed) >= CMP_W'(debounce_r)) &&
                          dec_en_r && !dec_skip_mid;
      dec_skip_nxt      = 1'b0;
    end
    dec_prev_nxt = s1_dec_r;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      combo_thresh_r <= COMBO_THRESHOLD_RESET;
      debounce_r     <= DEBOUNCE_RESET;
      inc_en_r       <= 1'b0;
      dec_en_r       <= 1'b0;
      combo_en_r     <= 1'b0;
    end else if (cfg_bus.valid) begin
      case (cfg_reg_t'(cfg_bus.index))
        REG_COMBO_THRESHOLD: combo_thresh_r <= cfg_bus.data;
        REG_DEBOUNCE:        debounce_r     <= cfg_bus.data;
        REG_INC_ENABLE:      inc_en_r       <= cfg_bus.data[0];
        REG_DEC_ENABLE:      dec_en_r       <= cfg_bus.data[0];
        REG_COMBO_ENABLE:    combo_en_r     <= cfg_bus.data[0];
        default: begin
        end
      endcase
    end
  end

  // Input register; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_v_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      s1_inc_r <= in_bus.inc_level;
      s1_dec_r <= in_bus.dec_level;
      s1_now_r <= TIME_BITS'(in_bus.now_ms);
    end
  end

  // Detector state only changes as a sample passes into the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_prev_r    <= 1'b1;
      inc_press_r   <= '0;
      inc_skip_r    <= 1'b0;
      dec_prev_r    <= 1'b1;
      dec_press_r   <= '0;
      dec_skip_r    <= 1'b0;
      hold_active_r <= 1'b0;
      hold_start_r  <= '0;
      hold_done_r   <= 1'b0;
    end else if (advance) begin
      inc_prev_r    <= inc_prev_nxt;
      inc_press_r   <= inc_press_nxt;
      inc_skip_r    <= inc_skip_nxt;
      dec_prev_r    <= dec_prev_nxt;
      dec_press_r   <= dec_press_nxt;
      dec_skip_r    <= dec_skip_nxt;
      hold_active_r <= hold_active_nxt;
      hold_start_r  <= hold_start_nxt;
      hold_done_r   <= hold_done_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  // A hold ends on the first sample that does not have both buttons held.
  a_hold_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !both_low) |=> !hold_active_r)
    else $error("hold still active after a sample with a button released");

  // The combo event only comes from a sample with both buttons held.
  a_combo_both_low: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_nxt.combo_event) |-> (!s1_inc_r && !s1_dec_r))
    else $error("combo event without both buttons held");

  // A both-held sample leaves both releases marked to be skipped.
  a_skip_set: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !s1_inc_r && !s1_dec_r) |=> (inc_skip_r && dec_skip_r))
    else $error("skip flags not set after a both-held sample");

  // Button events only come from a release of that button.
  a_inc_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_nxt.inc_event) |-> (s1_inc_r && !inc_prev_r))
    else $error("increment event without a release");

  // Input is refused only while a sample waits in the input register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> (s1_v_r && out_v_r && !out_bus.ready))
    else $error("input stalled without a waiting sample");

endmodule

[tb/sv/two_button_release_and_combo_detector_tb.sv]
// Self-checking testbench for the two-button release and combo detector.
// Needs tbrc_pkg, the three channel interfaces and the detector RTL.
// A directed script comes first, then random button sequences under
// several register settings and handshake pressures.
module two_button_release_and_combo_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tbrc_pkg::*;

  // Register slots past the end of the map; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  // The sample path is two registers deep, so a handful of cycles always
  // covers a beat still working its way through the block.
  localparam int DRAIN_CYCLES = 4;
  localparam int TAIL_CYCLES  = 8;
  // Far beyond the slowest correct run.
  localparam int RUN_LIMIT    = 200_000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 165;
  localparam int REPORT_MAX   = 10;

  localparam int INC_PIN = 0;
  localparam int DEC_PIN = 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  tbrc_in_if  in_bus ();
  tbrc_out_if out_bus ();
  tbrc_cfg_if cfg_bus ();

  two_button_release_and_combo_detector DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  // ---------------------------------------------------------------------
  // Predictor. It mirrors the register file and the per-button and hold
  // state, and is advanced once for every input beat the block accepts.
  // ---------------------------------------------------------------------
  typedef struct packed {
    logic             level;       // last sampled pin level, 1 is released
    logic [NOW_W-1:0] pressed_at;  // timestamp of the last falling edge
    logic             skip;        // a both-held moment since the last release
  } button_track_t;

  logic [CFG_DATA_W-1:0] combo_thr = COMBO_THRESHOLD_RESET;
  logic [CFG_DATA_W-1:0] debounce  = DEBOUNCE_RESET;
  logic                  inc_en    = 1'b0;
  logic                  dec_en    = 1'b0;
  logic                  combo_en  = 1'b0;

  button_track_t    pins [2] = '{'{1'b1, '0, 1'b0}, '{1'b1, '0, 1'b0}};
  logic             hold_on    = 1'b0;
  logic [NOW_W-1:0] hold_from  = '0;
  logic             hold_fired = 1'b0;

  // A rising edge is a release. It counts only if the press was long
  // enough, the button is enabled and no two-button hold came in between;
  // the skip flag is cleared on every release, counted or not.
  function automatic logic track_button(int pin, logic lvl, logic [NOW_W-1:0] t,
                                        logic enabled);
    logic             fired;
    logic [NOW_W-1:0] held;
    fired = 1'b0;
    if (pins[pin].level && !lvl) begin
      pins[pin].pressed_at = t;
    end else if (!pins[pin].level && lvl) begin
      held = t - pins[pin].pressed_at;
      fired = (held >= debounce) && enabled && !pins[pin].skip;
      pins[pin].skip = 1'b0;
    end
    pins[pin].level = lvl;
    return fired;
  endfunction

  // The hold is looked at before the buttons, so a both-held sample marks
  // both releases to be skipped before either edge is judged.
  function automatic result_t advance_detector(logic inc_l, logic dec_l,
                                               logic [NOW_W-1:0] t);
    result_t          flags;
    logic [NOW_W-1:0] held;
    flags = '0;
    if (!inc_l && !dec_l) begin
      pins[INC_PIN].skip = 1'b1;
      pins[DEC_PIN].skip = 1'b1;
      held = t - hold_from;
      if (!hold_on) begin
        // The opening sample of a hold never fires, whatever the threshold.
        hold_on    = 1'b1;
        hold_from  = t;
        hold_fired = 1'b0;
      end else if (!hold_fired && held >= combo_thr) begin
        // The hold is spent even when the combo output is disabled.
        hold_fired = 1'b1;
        flags.combo_event = combo_en;
      end
    end else begin
      hold_on = 1'b0;
    end
    flags.inc_event = track_button(INC_PIN, inc_l, t, inc_en);
    flags.dec_event = track_button(DEC_PIN, dec_l, t, dec_en);
    return flags;
  endfunction

  // ---------------------------------------------------------------------
  // Beat monitor and scoreboard. Everything is sampled at the rising edge,
  // where the driver's nonblocking updates have not yet landed.
  // ---------------------------------------------------------------------
  result_t expected_flags [$];
  int      fail_count   = 0;
  int      results_seen = 0;

  // Travels with each input beat: set when the script gives the result
  // outright, in which case it stands in for the predicted one.
  logic    beat_typed;
  result_t beat_flags;

  task automatic flag_error(string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endtask

  always @(posedge clk) begin
    result_t predicted;
    result_t want;
    result_t got;
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          REG_COMBO_THRESHOLD: combo_thr = cfg_bus.data;
          REG_DEBOUNCE:        debounce  = cfg_bus.data;
          REG_INC_ENABLE:      inc_en    = cfg_bus.data[0];
          REG_DEC_ENABLE:      dec_en    = cfg_bus.data[0];
          REG_COMBO_ENABLE:    combo_en  = cfg_bus.data[0];
          default: ;
        endcase
      end
      if (in_bus.valid && in_bus.ready) begin
        predicted = advance_detector(in_bus.inc_level, in_bus.dec_level, in_bus.now_ms);
        expected_flags.push_back(beat_typed ? beat_flags : predicted);
      end
      if (out_bus.valid && out_bus.ready) begin
        got = {out_bus.inc_event, out_bus.dec_event, out_bus.combo_event};
        if (expected_flags.size() == 0) begin
          flag_error($sformatf("result beat %0d arrived with none outstanding: %b%b%b",
                               results_seen, got.inc_event, got.dec_event,
                               got.combo_event));
        end else begin
          want = expected_flags.pop_front();
          if (got.inc_event !== want.inc_event || got.dec_event !== want.dec_event ||
              got.combo_event !== want.combo_event) begin
            flag_error($sformatf({"result beat %0d: inc/dec/combo expected %b%b%b, ",
                                  "got %b%b%b"}, results_seen, want.inc_event,
                                 want.dec_event, want.combo_event, got.inc_event,
                                 got.dec_event, got.combo_event));
          end
        end
        results_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Handshake pressure. The sink stalls at a rate set per phase.
  // ---------------------------------------------------------------------
  int unsigned send_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;

  always @(posedge clk) begin
    out_bus.ready <= rst_n && ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Offers one sample beat and returns at the edge that accepts it. Valid
  // is left high so that a following beat can go out back to back.
  task automatic send_sample(logic inc_l, logic dec_l, logic [NOW_W-1:0] t,
                             logic typed, result_t flags);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.inc_level <= inc_l;
    in_bus.dec_level <= dec_l;
    in_bus.now_ms    <= t;
    beat_typed       <= typed;
    beat_flags       <= flags;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // Waits until every outstanding result has come back, then lets the
  // pipeline settle. The caller has already dropped the input valid. The
  // first edge makes sure the monitor has logged the last accepted beat.
  task automatic wait_drained();
    @(posedge clk);
    while (expected_flags.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Directed script. A row either writes a register or sends a sample;
  // rows whose result is obvious carry it, the rest use the predictor.
  // ---------------------------------------------------------------------
  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic                  inc_level;
    logic                  dec_level;
    logic [NOW_W-1:0]      now_ms;
    logic                  typed;
    result_t               flags;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } script_row_t;

  function automatic script_row_t sample_row(logic inc_l, logic dec_l,
                                             logic [NOW_W-1:0] t);
    script_row_t r;
    r = '0;
    r.kind      = ROW_SAMPLE;
    r.inc_level = inc_l;
    r.dec_level = dec_l;
    r.now_ms    = t;
    return r;
  endfunction

  function automatic script_row_t checked_row(logic inc_l, logic dec_l,
                                              logic [NOW_W-1:0] t, result_t f);
    script_row_t r;
    r = sample_row(inc_l, dec_l, t);
    r.typed = 1'b1;
    r.flags = f;
    return r;
  endfunction

  function automatic script_row_t write_row(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] value);
    script_row_t r;
    r = '0;
    r.kind  = ROW_WRITE;
    r.index = idx;
    r.data  = value;
    return r;
  endfunction

  localparam int SCRIPT_LEN = 32;
  script_row_t script [SCRIPT_LEN];

  // Random sequence state: the pin levels and clock the generator walks.
  logic             gen_inc;
  logic             gen_dec;
  logic [NOW_W-1:0] gen_now;
  logic [NOW_W-1:0] gen_step;

  function automatic int unsigned step_span(logic [CFG_DATA_W-1:0] v);
    return (v > 32'd40000) ? 32'd80000 : 2 * v + 4;
  endfunction

  // Run timeout.
  int cycles_run = 0;

  initial begin
    while (cycles_run < RUN_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("two_button_release_and_combo_detector_tb: done, errors");
    $finish;
  end

  initial begin
    int pause_at;

    // Result flags below are written inc, dec, combo from left to right.
    script = '{
      // Fresh from reset every output is disabled, so nothing can fire.
      checked_row(1'b1, 1'b1, 32'd0, 3'b000),
      sample_row (1'b0, 1'b1, 32'd10),
      checked_row(1'b1, 1'b1, 32'd100, 3'b000),
      sample_row (1'b0, 1'b0, 32'd200),
      // The hold reaches its threshold here but the combo is disabled.
      checked_row(1'b0, 1'b0, 32'd5200, 3'b000),
      sample_row (1'b1, 1'b1, 32'd5300),
      write_row  (REG_INC_ENABLE, 32'h0000_0001),
      // Only the low bit of an enable register carries meaning.
      write_row  (REG_DEC_ENABLE, 32'hFFFF_FFFF),
      write_row  (REG_COMBO_ENABLE, 32'h0000_0001),
      sample_row (1'b1, 1'b1, 32'hFFFF_FFF0),
      sample_row (1'b1, 1'b0, 32'hFFFF_FFF8),
      // The press straddles the timestamp wrap and still lasts 56 ms.
      checked_row(1'b1, 1'b1, 32'h0000_0030, 3'b010),
      sample_row (1'b0, 1'b1, 32'd100),
      // One millisecond short of the debounce time.
      checked_row(1'b1, 1'b1, 32'd149, 3'b000),
      sample_row (1'b0, 1'b0, 32'd1000),
      write_row  (REG_COMBO_THRESHOLD, 32'd0),
      // A zero threshold fires on the second held sample, not the first.
      checked_row(1'b0, 1'b0, 32'd1000, 3'b001),
      sample_row (1'b0, 1'b0, 32'd2000),
      sample_row (1'b1, 1'b0, 32'd3000),
      sample_row (1'b1, 1'b1, 32'd3100),
      sample_row (1'b0, 1'b0, 32'd3200),
      write_row  (REG_COMBO_THRESHOLD, 32'hFFFF_FFFF),
      write_row  (REG_DEBOUNCE, 32'hFFFF_FFFF),
      // Stepping back one millisecond is the longest possible hold.
      checked_row(1'b0, 1'b0, 32'd3199, 3'b001),
      sample_row (1'b1, 1'b1, 32'd3300),
      sample_row (1'b0, 1'b1, 32'd0),
      checked_row(1'b1, 1'b1, 32'hFFFF_FFFF, 3'b100),
      write_row  (REG_DEBOUNCE, 32'd0),
      write_row  (REG_UNUSED_LO, 32'hDEAD_BEEF),
      write_row  (REG_UNUSED_HI, 32'h0000_0001),
      sample_row (1'b1, 1'b0, 32'd5),
      // With no debounce a press and release at one timestamp counts.
      checked_row(1'b1, 1'b1, 32'd5, 3'b010)
    };

    in_bus.valid     <= 1'b0;
    in_bus.inc_level <= 1'b1;
    in_bus.dec_level <= 1'b1;
    in_bus.now_ms    <= '0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.index    <= '0;
    cfg_bus.data     <= '0;
    beat_typed       <= 1'b0;
    beat_flags       <= '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers may only change while no beat is in flight.
    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        in_bus.valid <= 1'b0;
        wait_drained();
        write_reg(script[i].index, script[i].data);
      end else begin
        send_sample(script[i].inc_level, script[i].dec_level, script[i].now_ms,
                    script[i].typed, script[i].flags);
      end
    end

    // Random part. Each phase picks a register setting and an idling
    // pattern; the first two phases hold every timing register at an
    // extreme, the rest use short times so that events come often.
    for (int p = 0; p < PHASES; p++) begin
      in_bus.valid <= 1'b0;
      wait_drained();
      case (p)
        0: begin
          write_reg(REG_COMBO_THRESHOLD, 32'd0);
          write_reg(REG_DEBOUNCE, 32'd0);
        end
        1: begin
          write_reg(REG_COMBO_THRESHOLD, 32'hFFFF_FFFF);
          write_reg(REG_DEBOUNCE, 32'hFFFF_FFFF);
        end
        default: begin
          write_reg(REG_COMBO_THRESHOLD, $urandom_range(0, 400));
          write_reg(REG_DEBOUNCE, $urandom_range(0, 120));
        end
      endcase
      write_reg(REG_INC_ENABLE, (p < 2) ? 32'h1 : $urandom);
      write_reg(REG_DEC_ENABLE, (p < 2) ? 32'h1 : $urandom);
      write_reg(REG_COMBO_ENABLE, (p < 2) ? 32'h1 : $urandom);
      write_reg(REG_UNUSED_LO + CFG_IDX_W'(p % 3), $urandom);

      case (p % 4)
        0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin send_idle_pct = 45; sink_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  sink_stall_pct = 45; end
        default: begin send_idle_pct = 6; sink_stall_pct = 6; end
      endcase

      gen_now  = $urandom;
      pause_at = $urandom_range(20, PHASE_ITEMS - 20);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Once per phase the sender holds back until the block has emptied.
        if (n == pause_at) begin
          in_bus.valid <= 1'b0;
          wait_drained();
        end
        if ($urandom_range(0, 99) < 12) begin
          // Noise: any levels, any timestamp.
          {gen_inc, gen_dec} = 2'($urandom_range(0, 3));
          gen_now = $urandom;
        end else begin
          // A plausible button sequence: levels often hold, and time moves
          // on by steps scaled to the current debounce and threshold,
          // sometimes landing right on either boundary.
          if ($urandom_range(0, 9) >= 4) begin
            {gen_inc, gen_dec} = 2'($urandom_range(0, 3));
          end
          case ($urandom_range(0, 4))
            0:       gen_step = $urandom_range(0, 3);
            1:       gen_step = $urandom_range(0, step_span(debounce));
            2:       gen_step = $urandom_range(0, step_span(combo_thr));
            3:       gen_step = debounce + NOW_W'($urandom_range(0, 2)) - 1;
            default: gen_step = combo_thr + NOW_W'($urandom_range(0, 2)) - 1;
          endcase
          gen_now = gen_now + gen_step;
        end
        send_sample(gen_inc, gen_dec, gen_now, 1'b0, '0);
      end
    end

    in_bus.valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("two_button_release_and_combo_detector_tb: done, clean");
    end else begin
      $display("two_button_release_and_combo_detector_tb: done, errors");
    end
    $finish;
  end

endmodule

[two_button_release_and_combo_detector.f]
sv/tbrc_pkg.sv
sv/tbrc_in_if.sv
sv/tbrc_out_if.sv
sv/tbrc_cfg_if.sv
sv/two_button_release_and_combo_detector.sv
tb/sv/two_button_release_and_combo_detector_tb.sv
